FILE: src/lobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared word types, operation and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int MAX_ORDERS_DEF = 32;

  // Operation codes of an input word.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  // Status codes of the closing record.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP_ID  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FAK_NX  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        order_id;
    logic               is_sell;
    logic signed [31:0] limit_price;
    logic [31:0]        order_qty;
    logic               fill_and_kill;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         status;
    logic [31:0]        bid_order_id;
    logic signed [31:0] bid_price;
    logic [31:0]        ask_order_id;
    logic signed [31:0] ask_price;
    logic [31:0]        trade_qty;
    logic [5:0]         resting_count;
    logic               last;
  } out_word_t;

  // One buffered trade, held until the final resting count is known.
  typedef struct packed {
    logic [31:0]        bid_id;
    logic signed [31:0] bid_price;
    logic [31:0]        ask_id;
    logic signed [31:0] ask_price;
    logic [31:0]        qty;
  } trade_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       scan_start;
    logic       scan_step;
    logic       insert;
    logic       remove_found;
    logic       trade;
    logic       cleanup;
    logic       set_status;
    logic [2:0] status_code;
    logic       drain_start;
    logic       rd_issue;
    logic       load_trade;
    logic       load_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       scan_last;
    logic       found;
    logic       have_free;
    logic       fak_reject;
    logic       trade_ok;
    logic       drain_more;
    logic       out_done;
  } dp_sts_t;

endpackage

FILE: src/lobm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher datapath
// Slot storage, the one-slot-per-cycle scan for id, free slot and best
// prices, trade execution, the trade buffer and the output register.
// ----------------------------------------------------------------------------
module lobm_dp import lobm_pkg::*; #(
  parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int IDX_W = $clog2(MAX_ORDERS);
  localparam int CNT_W = $clog2(MAX_ORDERS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ORDERS);

  // Slot storage.
  logic               valid_r  [MAX_ORDERS];
  logic [31:0]        id_r     [MAX_ORDERS];
  logic               sell_r   [MAX_ORDERS];
  logic signed [31:0] price_r  [MAX_ORDERS];
  logic [31:0]        rem_r    [MAX_ORDERS];
  logic               fak_r    [MAX_ORDERS];
  logic [47:0]        arr_r    [MAX_ORDERS];

  logic [47:0]      arrival_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Current item.
  in_word_t req_r;
  logic [2:0] status_r;

  // Scan accumulators.
  logic [IDX_W-1:0]   idx_r;
  logic               found_r, free_r;
  logic [IDX_W-1:0]   found_idx_r, free_idx_r;
  logic               found_fak_r;
  logic               bid_have_r, ask_have_r;
  logic [IDX_W-1:0]   bid_idx_r, ask_idx_r;
  logic signed [31:0] bid_price_r, ask_price_r;
  logic [47:0]        bid_arr_r, ask_arr_r;
  logic [31:0]        bid_id_r, ask_id_r, bid_rem_r, ask_rem_r;
  logic               bid_fak_r, ask_fak_r;

  // Trade buffer.
  trade_t           tbuf [MAX_ORDERS];
  trade_t           tbuf_rd_r;
  logic [CNT_W-1:0] n_r, drain_r;

  out_word_t out_r;
  logic      out_valid_r;

  // Per-slot compare for the scan.
  logic cur_valid, cur_sell, bid_better, ask_better;
  logic signed [31:0] cur_price;
  logic [47:0] cur_arr;

  assign cur_valid = valid_r[idx_r];
  assign cur_sell  = sell_r[idx_r];
  assign cur_price = price_r[idx_r];
  assign cur_arr   = arr_r[idx_r];
  assign bid_better = cur_valid && !cur_sell &&
      (!bid_have_r || cur_price > bid_price_r ||
       (cur_price == bid_price_r && cur_arr < bid_arr_r));
  assign ask_better = cur_valid && cur_sell &&
      (!ask_have_r || cur_price < ask_price_r ||
       (cur_price == ask_price_r && cur_arr < ask_arr_r));

  // Trade quantity and leftovers.
  logic [31:0] tq, bid_left, ask_left;
  assign tq       = (bid_rem_r < ask_rem_r) ? bid_rem_r : ask_rem_r;
  assign bid_left = bid_rem_r - tq;
  assign ask_left = ask_rem_r - tq;

  logic do_kill_bid, do_kill_ask;
  assign do_kill_bid = bid_have_r && bid_fak_r;
  assign do_kill_ask = ask_have_r && ask_fak_r;

  // Resting count follows every insertion and removal.
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.remove_found) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.trade) begin
      count_nxt = count_r - CNT_W'(bid_left == 32'd0) - CNT_W'(ask_left == 32'd0);
    end else if (cmd.cleanup) begin
      count_nxt = count_r - CNT_W'(do_kill_bid) - CNT_W'(do_kill_ask);
    end
  end

  // Valid bits and control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDERS; i++) begin
        valid_r[i] <= 1'b0;
      end
      arrival_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.insert) begin
        valid_r[free_idx_r] <= 1'b1;
        arrival_r <= arrival_r + 48'd1;
      end
      if (cmd.remove_found) begin
        valid_r[found_idx_r] <= 1'b0;
      end
      if (cmd.trade) begin
        if (bid_left == 32'd0) begin
          valid_r[bid_idx_r] <= 1'b0;
        end
        if (ask_left == 32'd0) begin
          valid_r[ask_idx_r] <= 1'b0;
        end
      end
      if (cmd.cleanup) begin
        if (do_kill_bid) begin
          valid_r[bid_idx_r] <= 1'b0;
        end
        if (do_kill_ask) begin
          valid_r[ask_idx_r] <= 1'b0;
        end
      end
      if (cmd.load_trade || cmd.load_status) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot payload, scan state and item registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r    <= in_word;
      status_r <= ST_OK;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.insert) begin
      id_r[free_idx_r]    <= req_r.order_id;
      sell_r[free_idx_r]  <= req_r.is_sell;
      price_r[free_idx_r] <= req_r.limit_price;
      rem_r[free_idx_r]   <= req_r.order_qty;
      fak_r[free_idx_r]   <= req_r.fill_and_kill;
      arr_r[free_idx_r]   <= arrival_r;
      n_r <= '0;
    end
    if (cmd.latch) begin
      n_r <= '0;
    end
    // A modify re-enters as an add that keeps the order kind.
    if (cmd.remove_found) begin
      req_r.op            <= OP_ADD;
      req_r.fill_and_kill <= found_fak_r;
    end
    if (cmd.trade) begin
      rem_r[bid_idx_r] <= bid_left;
      rem_r[ask_idx_r] <= ask_left;
      tbuf[n_r[IDX_W-1:0]] <= '{bid_id: bid_id_r, bid_price: bid_price_r,
                                 ask_id: ask_id_r, ask_price: ask_price_r, qty: tq};
      n_r <= n_r + CNT_W'(1);
    end
    if (cmd.scan_start) begin
      idx_r      <= '0;
      found_r    <= 1'b0;
      free_r     <= 1'b0;
      bid_have_r <= 1'b0;
      ask_have_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (!found_r && cur_valid && id_r[idx_r] == req_r.order_id) begin
        found_r     <= 1'b1;
        found_idx_r <= idx_r;
        found_fak_r <= fak_r[idx_r];
      end
      if (!free_r && !cur_valid) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (bid_better) begin
        bid_have_r  <= 1'b1;
        bid_idx_r   <= idx_r;
        bid_price_r <= cur_price;
        bid_arr_r   <= cur_arr;
        bid_id_r    <= id_r[idx_r];
        bid_rem_r   <= rem_r[idx_r];
        bid_fak_r   <= fak_r[idx_r];
      end
      if (ask_better) begin
        ask_have_r  <= 1'b1;
        ask_idx_r   <= idx_r;
        ask_price_r <= cur_price;
        ask_arr_r   <= cur_arr;
        ask_id_r    <= id_r[idx_r];
        ask_rem_r   <= rem_r[idx_r];
        ask_fak_r   <= fak_r[idx_r];
      end
    end
    if (cmd.drain_start) begin
      drain_r <= '0;
    end
    if (cmd.rd_issue) begin
      tbuf_rd_r <= tbuf[drain_r[IDX_W-1:0]];
    end
    if (cmd.load_trade) begin
      drain_r <= drain_r + CNT_W'(1);
      out_r   <= '{kind: 1'b0, status: ST_OK,
                   bid_order_id: tbuf_rd_r.bid_id, bid_price: tbuf_rd_r.bid_price,
                   ask_order_id: tbuf_rd_r.ask_id, ask_price: tbuf_rd_r.ask_price,
                   trade_qty: tbuf_rd_r.qty, resting_count: 6'(count_r), last: 1'b0};
    end
    if (cmd.load_status) begin
      out_r <= '{kind: 1'b1, status: status_r, bid_order_id: 32'd0, bid_price: 32'sd0,
                 ask_order_id: 32'd0, ask_price: 32'sd0, trade_qty: 32'd0,
                 resting_count: 6'(count_r), last: 1'b1};
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.op         = req_r.op;
    sts.scan_last  = (idx_r == LAST_IDX);
    sts.found      = found_r;
    sts.have_free  = free_r;
    sts.fak_reject = req_r.fill_and_kill &&
        (req_r.is_sell ? (!bid_have_r || req_r.limit_price > bid_price_r)
                       : (!ask_have_r || req_r.limit_price < ask_price_r));
    sts.trade_ok   = bid_have_r && ask_have_r && (bid_price_r >= ask_price_r) &&
                     (n_r < CNT_MAX);
    sts.drain_more = (drain_r < n_r);
    sts.out_done   = out_valid_r && out_ready;
  end

  assign out_word  = out_r;
  assign out_valid = out_valid_r;

endmodule

FILE: src/lobm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher controller
// Sequences scans, the add and remove decisions, the matching loop and the
// delivery of buffered trades followed by the closing record.
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MSCAN, S_MDECIDE,
    S_EMIT, S_RD, S_LOAD, S_WAIT, S_WAIT_LAST
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch      = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_EMIT;
        if (sts.op == OP_ADD) begin
          if (sts.found) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DUP_ID;
          end else if (sts.fak_reject) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_FAK_NX;
          end else if (!sts.have_free) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_FULL;
          end else begin
            cmd.insert     = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_MSCAN;
          end
        end else if (sts.op == OP_CANCEL || sts.op == OP_MODIFY) begin
          if (!sts.found) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_UNKNOWN;
          end else begin
            cmd.remove_found = 1'b1;
            if (sts.op == OP_MODIFY) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        end
      end
      S_MSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_MDECIDE;
        end
      end
      S_MDECIDE: begin
        if (sts.trade_ok) begin
          cmd.trade      = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_MSCAN;
        end else begin
          cmd.cleanup = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.drain_start = 1'b1;
        state_nxt       = S_RD;
      end
      S_RD: begin
        if (sts.drain_more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_LOAD;
        end else begin
          cmd.load_status = 1'b1;
          state_nxt       = S_WAIT_LAST;
        end
      end
      S_LOAD: begin
        cmd.load_trade = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (sts.out_done) begin
          state_nxt = S_RD;
        end
      end
      S_WAIT_LAST: begin
        if (sts.out_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book matcher
// Bounded order book with price then time priority matching.
// ----------------------------------------------------------------------------
// Input words (add, cancel, modify) arrive on in_valid/in_ready; result words
// leave on out_valid/out_ready. Each input word gives zero or more trade
// words and then one closing status word with last set. Every result word
// carries the resting count after the whole input, so trades are buffered
// and delivered only once the input's work is done.
// One input word is handled at a time. Each pass over the book visits one
// slot per cycle. An add that enters the book takes one pass for the checks
// plus one pass per trade and a final pass, a modify one pass more and a
// cancel one pass; the trade words and the closing word follow.
// Reset empties the book and clears the arrival counter; no clearing pass
// is needed. When the receiver stalls, the output register holds the word
// and no new input word is taken until the closing word is delivered.
// ----------------------------------------------------------------------------
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Book storage and matching datapath.
  lobm_dp #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

FILE: sim/book_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book result checker
// Watches the input and result channels of the order book matcher, keeps its
// own copy of the book, predicts the trade and closing words of every
// accepted input word and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module book_checker import lobm_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        error_count,
  output int        pending_words,
  output int        trade_words,
  output int        status_seen [0:7]
);

  localparam int EXP_DEPTH = 256;

  // Model of the book.
  logic               bk_used   [DEPTH];
  logic [31:0]        bk_id     [DEPTH];
  logic               bk_sell   [DEPTH];
  logic signed [31:0] bk_price  [DEPTH];
  logic [31:0]        bk_left   [DEPTH];
  logic               bk_fak    [DEPTH];
  logic [47:0]        bk_seq    [DEPTH];
  logic [47:0]        seq_next;

  // Expected words in delivery order, and the trades of the current input.
  out_word_t exp_fifo [EXP_DEPTH];
  int        exp_head;
  int        exp_tail;
  out_word_t trade_hold [DEPTH];
  int        trade_cnt;

  function automatic void exp_put(out_word_t w);
    exp_fifo[exp_tail % EXP_DEPTH] = w;
    exp_tail++;
  endfunction

  function automatic int locate(logic [31:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (bk_used[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // Best order on one side: price first, then earliest arrival.
  function automatic int best_on(logic sell);
    int b;
    b = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_used[i] || bk_sell[i] != sell) continue;
      if (b < 0) b = i;
      else if ((sell ? bk_price[i] < bk_price[b] : bk_price[i] > bk_price[b]) ||
               (bk_price[i] == bk_price[b] && bk_seq[i] < bk_seq[b])) b = i;
    end
    return b;
  endfunction

  function automatic logic [2:0] enter_order(logic [31:0] id, logic sell,
      logic signed [31:0] price, logic [31:0] qty, logic fak);
    int o, s, b, a;
    logic [31:0] q;
    out_word_t t;
    if (locate(id) >= 0) return ST_DUP_ID;
    if (fak) begin
      o = best_on(!sell);
      if (o < 0) return ST_FAK_NX;
      if (sell ? price > bk_price[o] : price < bk_price[o]) return ST_FAK_NX;
    end
    s = -1;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (!bk_used[i]) s = i;
    if (s < 0) return ST_FULL;
    bk_used[s] = 1'b1;
    bk_id[s] = id;
    bk_sell[s] = sell;
    bk_price[s] = price;
    bk_left[s] = qty;
    bk_fak[s] = fak;
    bk_seq[s] = seq_next;
    seq_next = seq_next + 48'd1;
    // Cross the book while the best bid reaches the best ask.
    while (trade_cnt < DEPTH) begin
      b = best_on(1'b0);
      a = best_on(1'b1);
      if (b < 0 || a < 0) break;
      if (bk_price[b] < bk_price[a]) break;
      q = (bk_left[b] < bk_left[a]) ? bk_left[b] : bk_left[a];
      bk_left[b] -= q;
      bk_left[a] -= q;
      t = '0;
      t.bid_order_id = bk_id[b];
      t.bid_price = bk_price[b];
      t.ask_order_id = bk_id[a];
      t.ask_price = bk_price[a];
      t.trade_qty = q;
      trade_hold[trade_cnt] = t;
      trade_cnt++;
      if (bk_left[b] == 0) bk_used[b] = 1'b0;
      if (bk_left[a] == 0) bk_used[a] = 1'b0;
    end
    // A fill-and-kill order left at the front of a best level is dropped.
    b = best_on(1'b0);
    if (b >= 0 && bk_fak[b]) bk_used[b] = 1'b0;
    a = best_on(1'b1);
    if (a >= 0 && bk_fak[a]) bk_used[a] = 1'b0;
    return ST_OK;
  endfunction

  task automatic apply_word(in_word_t w);
    logic [2:0] st;
    int s, cnt;
    out_word_t c;
    st = ST_OK;
    trade_cnt = 0;
    if (w.op == OP_ADD) begin
      st = enter_order(w.order_id, w.is_sell, w.limit_price, w.order_qty,
                       w.fill_and_kill);
    end else if (w.op == OP_CANCEL || w.op == OP_MODIFY) begin
      s = locate(w.order_id);
      if (s < 0) st = ST_UNKNOWN;
      else begin
        bk_used[s] = 1'b0;
        if (w.op == OP_MODIFY)
          st = enter_order(w.order_id, w.is_sell, w.limit_price, w.order_qty,
                           bk_fak[s]);
      end
    end
    cnt = 0;
    for (int i = 0; i < DEPTH; i++) if (bk_used[i]) cnt++;
    for (int k = 0; k < trade_cnt; k++) begin
      trade_hold[k].resting_count = cnt[5:0];
      exp_put(trade_hold[k]);
    end
    c = '0;
    c.kind = 1'b1;
    c.status = st;
    c.resting_count = cnt[5:0];
    c.last = 1'b1;
    exp_put(c);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic compare_word(out_word_t g);
    out_word_t e;
    if (exp_tail == exp_head) begin
      $display("MISMATCH at %0t: result word with nothing expected", $realtime);
      error_count++;
      return;
    end
    e = exp_fifo[exp_head % EXP_DEPTH];
    exp_head++;
    if (g.kind != e.kind) report("kind", g.kind, e.kind);
    if (g.status != e.status) report("status", g.status, e.status);
    if (g.bid_order_id != e.bid_order_id) report("bid_order_id", g.bid_order_id, e.bid_order_id);
    if (g.bid_price != e.bid_price) report("bid_price", g.bid_price, e.bid_price);
    if (g.ask_order_id != e.ask_order_id) report("ask_order_id", g.ask_order_id, e.ask_order_id);
    if (g.ask_price != e.ask_price) report("ask_price", g.ask_price, e.ask_price);
    if (g.trade_qty != e.trade_qty) report("trade_qty", g.trade_qty, e.trade_qty);
    if (g.resting_count != e.resting_count)
      report("resting_count", g.resting_count, e.resting_count);
    if (g.last != e.last) report("last", g.last, e.last);
    if (e.kind) status_seen[e.status]++;
    else trade_words++;
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) bk_used[i] = 1'b0;
      seq_next = '0;
      exp_head = 0;
      exp_tail = 0;
    end else begin
      if (out_valid && out_ready) compare_word(out_word);
      if (in_valid && in_ready) apply_word(in_word);
    end
    pending_words = exp_tail - exp_head;
  end

  initial begin
    error_count = 0;
    trade_words = 0;
    exp_head = 0;
    exp_tail = 0;
    trade_cnt = 0;
    pending_words = 0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher testbench
// Drives directed and random order words in bursts, stalls the result side,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench import lobm_pkg::*; ();

  localparam int  DEPTH       = 32;
  localparam int  RANDOM_WORDS = 380;
  localparam longint CYCLE_LIMIT = 4000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        error_count;
  int        pending_words;
  int        trade_words;
  int        status_seen [0:7];
  longint    cycle_count;
  int        words_sent;
  logic [31:0] id_pool [16];

  limit_order_book_matcher #(.MAX_ORDERS(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  book_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .error_count(error_count), .pending_words(pending_words),
    .trade_words(trade_words), .status_seen(status_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls on its own pattern: calm stretches and choppy ones.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (cycle_count % 3000 < 600) out_ready <= 1'b1;
    else if (cycle_count % 3000 < 1200) out_ready <= ($urandom_range(0, 9) == 0);
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic [1:0] op, logic [31:0] id, logic sell,
                           logic [31:0] price, logic [31:0] qty, logic fak);
    in_word_t w;
    w.op = op;
    w.order_id = id;
    w.is_sell = sell;
    w.limit_price = price;
    w.order_qty = qty;
    w.fill_and_kill = fak;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [1:0] op;
    logic [31:0] id, price, qty;
    r = $urandom_range(0, 99);
    // Mostly well-formed book traffic on a small id pool and a tight price band.
    if (r < 55) op = OP_ADD;
    else if (r < 72) op = OP_CANCEL;
    else if (r < 92) op = OP_MODIFY;
    else op = 2'd3;
    id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 15)];
    price = ($urandom_range(0, 14) == 0) ? $urandom() : 32'd100 + $urandom_range(0, 8) - 4;
    case ($urandom_range(0, 9))
      0: qty = $urandom();
      1: qty = 32'd0;
      default: qty = $urandom_range(1, 50);
    endcase
    send_word(op, id, $urandom_range(0, 1), price, qty, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    cycle_count = 0;
    words_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    for (int i = 0; i < 16; i++) id_pool[i] = (i == 15) ? 32'hFFFF_FFFF : i * 7 + 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, refusals, special cases.
    send_word(OP_ADD, 32'h0, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_ADD, 32'h0, 1'b1, 32'h0, 32'd5, 1'b0);               // duplicate id
    send_word(OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'd10, 1'b0); // crosses
    send_word(OP_ADD, 32'd9, 1'b0, 32'd50, 32'd3, 1'b1);              // fak, no cross
    send_word(OP_ADD, 32'd10, 1'b1, 32'd60, 32'd0, 1'b0);             // zero quantity
    send_word(OP_ADD, 32'd11, 1'b0, 32'd60, 32'd4, 1'b0);             // no ask rests, so no trade
    send_word(OP_CANCEL, 32'd1234, 1'b0, 32'd0, 32'd0, 1'b0);         // unknown id
    send_word(OP_MODIFY, 32'd1234, 1'b0, 32'd0, 32'd0, 1'b0);
    send_word(2'd3, 32'hA5A5_5A5A, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_ADD, 32'd12, 1'b1, 32'd70, 32'd2, 1'b0);
    send_word(OP_ADD, 32'd13, 1'b0, 32'd75, 32'd1, 1'b1);             // fak with no ask, refused
    send_word(OP_ADD, 32'd14, 1'b1, 32'd90, 32'd6, 1'b0);
    send_word(OP_ADD, 32'd15, 1'b0, 32'd10, 32'd6, 1'b1);             // fak refused
    send_word(OP_MODIFY, 32'd14, 1'b1, 32'd20, 32'd1, 1'b0);          // id 14 already filled: unknown
    send_word(OP_CANCEL, 32'd12, 1'b0, 32'd0, 32'd0, 1'b0);
    // Send DEPTH + 1 small asks that cross the resting top bid, then a large bid.
    for (int i = 0; i < DEPTH + 1; i++)
      send_word(OP_ADD, 32'd200 + i, 1'b1, 32'd500 + (i % 3), 32'd1, 1'b0);
    send_word(OP_ADD, 32'd300, 1'b0, 32'h7FFF_FFFF, 32'd40, 1'b0);
    send_word(OP_CANCEL, 32'd300, 1'b0, 32'd0, 32'd0, 1'b0);
    send_word(OP_CANCEL, 32'h0, 1'b0, 32'd0, 32'd0, 1'b0);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);

    // Random: bursts with gaps.
    for (int n = 0; n < RANDOM_WORDS; ) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++) send_random();
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    in_valid <= 1'b0;

    while (pending_words != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d order words; %0d trade words checked.", words_sent, trade_words);
    $display("Closing status counts ok/dup/unknown/fak/full: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0 && pending_words == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
